### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, switched off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### hdl/bmpru_pkg.sv
package bmpru_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PALETTE_DEPTH = 256;

   localparam int DIM_W     = 13;
   localparam int PAL_AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic MODE_PALETTE = 1'b0;
   localparam logic MODE_BGR     = 1'b1;

   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_DATA    = 1'b1;

   typedef logic [7:0] octet_type;

   // one accepted item as seen by the output pipeline
   typedef struct packed {
      logic      emit;
      logic      direct;
      logic      pal_hit;
      octet_type red;
      octet_type green;
      octet_type blue;
      logic      row_last;
      logic      image_last;
   } pix_event_type;

   // write and read command for the palette memory
   typedef struct packed {
      logic              wr_en;
      logic [PAL_AW-1:0] wr_addr;
      logic [23:0]       wr_data;
      logic              rd_en;
      logic [PAL_AW-1:0] rd_addr;
   } pal_cmd_type;

endpackage

### hdl/bmpru_palette.sv
module bmpru_palette (
   input  logic                  clock,
   input  bmpru_pkg::pal_cmd_type cmd,
   output logic [23:0]           rd_data
);

   logic [23:0] mem [bmpru_pkg::PALETTE_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bmpru_ctrl.sv
`include "assert_macros.svh"

module bmpru_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bmpru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmpru_pkg::DIM_W-1:0]         csr_wdata,
   input  logic                                accept,
   input  logic                                req_type,
   input  logic [39:0]                         req_fields,
   output bmpru_pkg::pix_event_type            event_out,
   output bmpru_pkg::pal_cmd_type              pal_cmd
);

   localparam int W = bmpru_pkg::DIM_W;

   logic         mode_ff, mode_in;
   logic [W-1:0] width_ff, width_in;
   logic [W-1:0] height_ff, height_in;
   logic [15:0]  gath_ff, gath_in;
   logic [1:0]   phase_ff, phase_in;
   logic [W-1:0] col_ff, col_in;
   logic [W-1:0] row_ff, row_in;
   logic [1:0]   pad_ff, pad_in;

   logic         csr_wr;
   logic [W-1:0] w_eff, h_eff;
   logic [7:0]   data_byte, pal_index;
   logic         is_data, padding, pix_byte, emit, row_last, image_last;
   logic [1:0]   row_bytes_lo, pad_new;

   function automatic logic [W-1:0] clamp_dim(input logic [W-1:0] v,
                                              input logic [W-1:0] maxv);
      logic [W-1:0] r;
      if (v == '0) begin
         r = W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   assign pal_index = req_fields[7:0];
   assign data_byte = req_fields[39:32];

   assign w_eff = clamp_dim(width_ff, W'(bmpru_pkg::MAX_WIDTH));
   assign h_eff = clamp_dim(height_ff, W'(bmpru_pkg::MAX_HEIGHT));

   assign is_data  = accept && (req_type == bmpru_pkg::REQ_DATA);
   assign padding  = (pad_ff != 2'd0);
   assign pix_byte = is_data && !padding;
   assign emit     = pix_byte && ((mode_ff == bmpru_pkg::MODE_PALETTE) || (phase_ff == 2'd2));

   assign row_last   = ({1'b0, col_ff} + (W+1)'(1)) >= {1'b0, w_eff};
   assign image_last = row_last && (({1'b0, row_ff} + (W+1)'(1)) >= {1'b0, h_eff});

   // row length mod 4 decides the padding up to the next 32-bit boundary
   assign row_bytes_lo = (mode_ff == bmpru_pkg::MODE_PALETTE) ? w_eff[1:0]
                                                              : 2'(w_eff[1:0] * 2'd3);
   assign pad_new = 2'd0 - row_bytes_lo;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      gath_in   = gath_ff;
      phase_in  = phase_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;

      if (is_data && padding) begin
         pad_in = pad_ff - 2'd1;
      end

      if (pix_byte && (mode_ff == bmpru_pkg::MODE_BGR)) begin
         case (phase_ff)
            2'd0: begin
               gath_in  = {8'd0, data_byte};
               phase_in = 2'd1;
            end
            2'd1: begin
               gath_in  = {data_byte, gath_ff[7:0]};
               phase_in = 2'd2;
            end
            default: begin
               phase_in = 2'd0;
            end
         endcase
      end

      if (emit) begin
         if (row_last) begin
            col_in = '0;
            row_in = image_last ? '0 : row_ff + W'(1);
            pad_in = pad_new;
         end else begin
            col_in = col_ff + W'(1);
         end
      end

      if (csr_wr) begin
         case (csr_index)
            bmpru_pkg::CSR_PIXEL_MODE: begin
               mode_in  = csr_wdata[0];
               phase_in = 2'd0;
               gath_in  = '0;
            end
            bmpru_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            bmpru_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bmpru_pkg::MODE_BGR;
         width_ff  <= W'(1);
         height_ff <= W'(1);
         gath_ff   <= '0;
         phase_ff  <= 2'd0;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= 2'd0;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         gath_ff   <= gath_in;
         phase_ff  <= phase_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
      end
   end

   always_comb begin
      event_out.emit       = emit;
      event_out.direct     = (mode_ff == bmpru_pkg::MODE_BGR);
      event_out.pal_hit    = ({1'b0, data_byte} < 9'(bmpru_pkg::PALETTE_DEPTH));
      event_out.red        = data_byte;
      event_out.green      = gath_ff[15:8];
      event_out.blue       = gath_ff[7:0];
      event_out.row_last   = row_last;
      event_out.image_last = image_last;
   end

   always_comb begin
      pal_cmd.wr_en   = accept && (req_type == bmpru_pkg::REQ_PALETTE)
                        && ({1'b0, pal_index} < 9'(bmpru_pkg::PALETTE_DEPTH));
      pal_cmd.wr_addr = pal_index[bmpru_pkg::PAL_AW-1:0];
      pal_cmd.wr_data = {req_fields[15:8], req_fields[23:16], req_fields[31:24]};
      pal_cmd.rd_en   = is_data;
      pal_cmd.rd_addr = data_byte[bmpru_pkg::PAL_AW-1:0];
   end

   // padding is only ever armed at the end of a complete pixel
   `ASSERT_IMPLY(a_pad_no_partial, clock, reset, pad_ff != 2'd0, phase_ff == 2'd0)
   `ASSERT_IMPLY(a_col_in_range, clock, reset, 1'b1,
                 col_ff < W'(bmpru_pkg::MAX_WIDTH) && row_ff < W'(bmpru_pkg::MAX_HEIGHT))

endmodule

### hdl/bmpru_out.sv
`include "assert_macros.svh"

module bmpru_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  bmpru_pkg::pix_event_type event_in,
   input  logic [23:0]              pal_rd_data,
   output logic                     take_ok,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   logic                     s1_valid_ff, s1_valid_in;
   bmpru_pkg::pix_event_type s1_ev_ff, s1_ev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_user_ff, rsp_user_in;

   logic       out_free, s1_move;
   logic [7:0] red, green, blue;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_move  = s1_valid_ff && out_free;
   assign take_ok  = !s1_valid_ff || out_free;

   // palette data arrives in the cycle after the read, alongside the stage-1 item
   always_comb begin
      if (s1_ev_ff.direct) begin
         red   = s1_ev_ff.red;
         green = s1_ev_ff.green;
         blue  = s1_ev_ff.blue;
      end else if (s1_ev_ff.pal_hit) begin
         red   = pal_rd_data[23:16];
         green = pal_rd_data[15:8];
         blue  = pal_rd_data[7:0];
      end else begin
         red   = 8'd0;
         green = 8'd0;
         blue  = 8'd0;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_ev_in     = s1_ev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      if (accept) begin
         s1_valid_in = event_in.emit;
         s1_ev_in    = event_in;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {bmpru_pkg::ALPHA_OPAQUE, blue, green, red};
         rsp_last_in  = s1_ev_ff.row_last;
         rsp_user_in  = s1_ev_ff.image_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ev_ff    <= s1_ev_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // hold the pending pixel while the output register is blocked
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_free,
                s1_valid_ff && $stable(s1_ev_ff))
   `ASSERT_IMPLY(a_image_ends_row, clock, reset, rsp_valid_ff && rsp_user_ff, rsp_last_ff)

endmodule

### hdl/bmp_pixel_rgba_unpacker_top.sv
// channel | direction | tdata / payload                               | tuser / tlast
// req_    | in        | index, red, green, blue, data byte (40 bits)  | tuser: item kind
// rsp_    | out       | red, green, blue, alpha (32 bits)             | tlast: row end, tuser: image end
// csr_    | in        | csr_index selects register, csr_wdata value   | -
//
// One byte is taken per cycle while req_tready is high; a pixel's last byte is registered in
// stage 1 with the palette read, then moves to the output register, which offers it on rsp_.
// Reset is synchronous, clears counters and sets BGR mode and a 1 x 1 image; palette contents are undefined.
// A stalled output holds one pixel in the output register and one in stage 1 before
// req_tready drops.
module bmp_pixel_rgba_unpacker_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [39:0]                         req_tdata,  // palette_index, palette_red,
                                                           // palette_green, palette_blue,
                                                           // data_byte
   input  logic                                req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // red, green, blue, alpha
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,  // image_last
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bmpru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmpru_pkg::DIM_W-1:0]         csr_wdata
);

   logic                     accept;
   logic                     take_ok;
   bmpru_pkg::pix_event_type pix_event;
   bmpru_pkg::pal_cmd_type   pal_cmd;
   logic [23:0]              pal_rd_data;

   assign req_tready = take_ok;
   assign accept     = req_tvalid && take_ok;

   bmpru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .req_type   (req_tuser),
      .req_fields (req_tdata),
      .event_out  (pix_event),
      .pal_cmd    (pal_cmd)
   );

   bmpru_palette u_palette (
      .clock   (clock),
      .cmd     (pal_cmd),
      .rd_data (pal_rd_data)
   );

   bmpru_out u_out (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .event_in    (pix_event),
      .pal_rd_data (pal_rd_data),
      .take_ok     (take_ok),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
